// File: src/zsc_pkg.sv
// shared types and constants of the smoothed z-score peak detector
// no dependencies

package zsc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LAG_W      = 6;
    localparam int THR_W      = 16;
    localparam int INFL_W     = 16;

    localparam logic [LAG_W-1:0]  LAG_RST  = 6'd15;
    localparam logic [THR_W-1:0]  THR_RST  = 16'd14336;
    localparam logic [INFL_W-1:0] INFL_RST = 16'd16384;

    // influence is q1.15, threshold q4.12 squared gives 2^24
    localparam logic [INFL_W-1:0] INFL_ONE  = 16'h8000;
    localparam int                BLEND_RND = 16384;
    localparam int                BLEND_FRAC = 15;
    localparam int                THR_SHIFT = 24;

    localparam logic signed [1:0] SIG_NONE   = 2'sb00;
    localparam logic signed [1:0] SIG_PEAK   = 2'sb01;
    localparam logic signed [1:0] SIG_TROUGH = 2'sb11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAG  = 2'd0,
        CFG_THR  = 2'd1,
        CFG_INFL = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_DECIDE,
        S_SQUARE,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic flag;
        logic pos;
    } t_verdict;

endpackage

// File: src/zsc_if.sv
// valid/ready channel interfaces: sample requests, results, register writes
// depends on zsc_pkg

interface zsc_smp_if #(parameter int W = 16) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface zsc_res_if #(parameter int W = 16) ();
    logic                valid;
    logic                ready;
    logic signed [1:0]   signal;
    logic signed [W-1:0] filtered;
    logic                primed;

    modport source (output valid, output signal, output filtered, output primed, input ready);
    modport sink (input valid, input signal, input filtered, input primed, output ready);
endinterface

interface zsc_cfg_if import zsc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/smoothed_zscore_peak_detector.sv
// top level: sequencer, window ring in ram, running sums, registers, result register
// depends on zsc_pkg, zsc_if, zsc_ram, zsc_arith
//
//  port    dir   modport  payload
//  i_smp   in    sink     sample (SAMPLE_BITS, signed)
//  o_res   out   source   signal (2, signed), filtered (SAMPLE_BITS, signed), primed (1)
//  i_cfg   in    sink     index (2), data (16); 0 lag, 1 threshold, 2 influence
//
// one item at a time: the acceptance cycle, then seven steps through the
// chain of dependent multiplies (deviation, spread, two threshold products,
// blend, square) and the ring write-back through the one ram port pair
// synchronous active-low reset restores register defaults and empties the window;
// ram contents are not cleared, only entries of the current fill are read
// full output register holds commit; register writes only when idle, ahead of samples

module smoothed_zscore_peak_detector import zsc_pkg::*; #(
    parameter int WINDOW_DEPTH = 64,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    zsc_smp_if.sink   i_smp,
    zsc_res_if.source o_res,
    zsc_cfg_if.sink   i_cfg
);

    localparam int B  = SAMPLE_BITS;
    localparam int NW = $clog2(WINDOW_DEPTH + 1);
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int SW = B + NW;
    localparam int QW = 2 * B + NW - 2;

    t_state r_state;
    t_state n_state;

    logic [LAG_W-1:0]    r_lag;
    logic [THR_W-1:0]    r_thr;
    logic [INFL_W-1:0]   r_infl;
    logic [AW-1:0]       r_ptr;
    logic [NW-1:0]       r_fill;
    logic signed [SW-1:0] r_sum;
    logic [QW-1:0]       r_sq;
    logic signed [B-1:0] r_last;
    logic signed [B-1:0] r_y;
    logic                r_primed;

    logic                r_out_valid;
    logic signed [1:0]   r_out_sig;
    logic signed [B-1:0] r_out_filt;
    logic                r_out_primed;

    logic [LAG_W:0]      w_nfull;
    logic [NW-1:0]       w_n;
    logic [NW-1:0]       w_ptr_inc;
    logic                w_accept;
    logic                w_cfg_we;
    logic                w_out_free;
    logic                w_commit;
    logic [B-1:0]        w_old_raw;
    logic signed [B-1:0] w_old;
    t_verdict            w_verdict;
    logic signed [B-1:0] w_filt;
    logic [QW-1:0]       w_oldsq;
    logic [QW-1:0]       w_fsq;
    logic signed [SW-1:0] w_old_sub;
    logic [QW-1:0]       w_oldsq_sub;

    assign w_nfull   = {1'b0, r_lag} + (LAG_W + 1)'(1);
    assign w_n       = (32'(w_nfull) > WINDOW_DEPTH) ? NW'(WINDOW_DEPTH) : NW'(w_nfull);
    assign w_ptr_inc = NW'(r_ptr) + NW'(1);

    assign i_cfg.ready = (r_state == S_IDLE);
    assign i_smp.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign w_accept    = i_smp.valid && i_smp.ready;
    assign w_cfg_we    = i_cfg.valid && i_cfg.ready;
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_commit    = (r_state == S_COMMIT) && w_out_free;

    assign w_old       = $signed(w_old_raw);
    assign w_old_sub   = r_primed ? SW'(w_old) : '0;
    assign w_oldsq_sub = r_primed ? w_oldsq : '0;

    zsc_ram #(
        .WIDTH (B),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_commit),
        .i_waddr (r_ptr),
        .i_wdata ($unsigned(w_filt)),
        .i_re    (w_accept),
        .i_raddr (r_ptr),
        .o_rdata (w_old_raw)
    );

    zsc_arith #(
        .B  (B),
        .NW (NW)
    ) u_arith (
        .i_clk     (i_clk),
        .i_state   (r_state),
        .i_primed  (r_primed),
        .i_n       (w_n),
        .i_y       (r_y),
        .i_last    (r_last),
        .i_old     (w_old),
        .i_sum     (r_sum),
        .i_sq      (r_sq),
        .i_thr     (r_thr),
        .i_infl    (r_infl),
        .o_verdict (w_verdict),
        .o_filt    (w_filt),
        .o_oldsq   (w_oldsq),
        .o_fsq     (w_fsq)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_MUL1;
            S_MUL1:   n_state = S_MUL2;
            S_MUL2:   n_state = S_MUL3;
            S_MUL3:   n_state = S_MUL4;
            S_MUL4:   n_state = S_DECIDE;
            S_DECIDE: n_state = S_SQUARE;
            S_SQUARE: n_state = S_COMMIT;
            S_COMMIT: if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_y      <= i_smp.sample;
            r_primed <= (r_fill >= w_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lag  <= LAG_RST;
            r_thr  <= THR_RST;
            r_infl <= INFL_RST;
            r_ptr  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
            r_sq   <= '0;
            r_last <= '0;
        end else if (w_commit) begin
            r_sum  <= r_sum - w_old_sub + SW'(w_filt);
            r_sq   <= r_sq - w_oldsq_sub + w_fsq;
            r_last <= w_filt;
            r_ptr  <= (w_ptr_inc >= w_n) ? '0 : AW'(w_ptr_inc);
            if (!r_primed) begin
                r_fill <= r_fill + NW'(1);
            end
        end else if (w_cfg_we) begin
            case (i_cfg.index)
                CFG_LAG: begin
                    r_lag  <= i_cfg.data[LAG_W-1:0];
                    r_ptr  <= '0;
                    r_fill <= '0;
                    r_sum  <= '0;
                    r_sq   <= '0;
                end
                CFG_THR:  r_thr  <= i_cfg.data[THR_W-1:0];
                CFG_INFL: r_infl <= i_cfg.data[INFL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_sig    <= w_verdict.flag ? (w_verdict.pos ? SIG_PEAK : SIG_TROUGH) : SIG_NONE;
            r_out_filt   <= w_filt;
            r_out_primed <= r_primed;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.signal   = r_out_sig;
    assign o_res.filtered = r_out_filt;
    assign o_res.primed   = r_out_primed;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_n)
        else $error("fill count beyond window length");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        NW'(r_ptr) < w_n)
        else $error("write pointer beyond window length");

    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_COMMIT))
        else $error("result appeared without a commit step");

    a_flag_needs_primed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.signal != SIG_NONE) |-> o_res.primed)
        else $error("deviation flagged while window still filling");
`endif

endmodule

// File: src/zsc_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module zsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/zsc_arith.sv
// multiply chain: deviation and spread products, threshold test, blend, squares
// depends on zsc_pkg; stepped by the sequencer state of the top level

module zsc_arith import zsc_pkg::*; #(
    parameter int B  = 16,
    parameter int NW = 7
) (
    input  logic                    i_clk,
    input  t_state                  i_state,
    input  logic                    i_primed,
    input  logic [NW-1:0]           i_n,
    input  logic signed [B-1:0]     i_y,
    input  logic signed [B-1:0]     i_last,
    input  logic signed [B-1:0]     i_old,
    input  logic signed [B+NW-1:0]  i_sum,
    input  logic [2*B+NW-3:0]       i_sq,
    input  logic [THR_W-1:0]        i_thr,
    input  logic [INFL_W-1:0]       i_infl,
    output t_verdict                o_verdict,
    output logic signed [B-1:0]     o_filt,
    output logic [2*B+NW-3:0]       o_oldsq,
    output logic [2*B+NW-3:0]       o_fsq
);

    localparam int SW   = B + NW;
    localparam int QW   = 2 * B + NW - 2;
    localparam int DW   = NW + B + 1;
    localparam int MW   = NW + B;
    localparam int VW   = NW + QW;
    localparam int LW   = 2 * MW;
    localparam int TW   = VW + THR_W;
    localparam int RW   = VW + 2 * THR_W;
    localparam int CW   = (LW + THR_SHIFT > RW) ? LW + THR_SHIFT : RW;
    localparam int PW   = B + INFL_W + 1;
    localparam int ACCW = PW + 1;

    logic [INFL_W-1:0]      w_w;
    logic [INFL_W-1:0]      w_wc;
    logic signed [DW-1:0]   w_ny;
    logic signed [DW-1:0]   w_d;
    logic [VW-1:0]          w_nq;
    logic signed [2*SW-1:0] w_s2;
    logic signed [2*B-1:0]  w_osq;
    logic signed [PW-1:0]   w_wy;
    logic signed [PW-1:0]   w_wl;
    logic signed [DW-1:0]   w_dneg;
    logic [MW-1:0]          w_dmag;
    logic [LW-1:0]          w_dmag2;
    logic [TW-1:0]          w_vt;
    logic [RW-1:0]          w_rhs;
    logic [CW-1:0]          w_lhs_c;
    logic [CW-1:0]          w_rhs_c;
    logic signed [ACCW-1:0] w_acc;
    logic signed [B-1:0]    w_blend;
    logic                   w_flag;
    logic signed [2*B-1:0]  w_fsq;

    logic signed [DW-1:0]   r_d;
    logic [VW-1:0]          r_nq;
    logic [VW-1:0]          r_s2;
    logic [QW-1:0]          r_oldsq;
    logic signed [PW-1:0]   r_wy;
    logic signed [PW-1:0]   r_wl;
    logic [LW-1:0]          r_dmag2;
    logic                   r_dpos;
    logic [VW-1:0]          r_var;
    logic [TW-1:0]          r_vt;
    logic [RW-1:0]          r_rhs;
    logic                   r_flag;
    logic                   r_pos;
    logic signed [B-1:0]    r_filt;
    logic [QW-1:0]          r_fsq;

    assign w_w   = (i_infl > INFL_ONE) ? INFL_ONE : i_infl;
    assign w_wc  = INFL_ONE - w_w;
    assign w_ny  = $signed({1'b0, i_n}) * i_y;
    assign w_d   = w_ny - DW'(i_sum);
    assign w_nq  = i_n * i_sq;
    assign w_s2  = i_sum * i_sum;
    assign w_osq = i_old * i_old;
    assign w_wy  = $signed({1'b0, w_w}) * i_y;
    assign w_wl  = $signed({1'b0, w_wc}) * i_last;

    assign w_dneg  = -r_d;
    assign w_dmag  = r_d[DW-1] ? MW'($unsigned(w_dneg)) : MW'($unsigned(r_d));
    assign w_dmag2 = w_dmag * w_dmag;
    assign w_vt    = r_var * i_thr;
    assign w_rhs   = r_vt * i_thr;

    assign w_lhs_c = CW'({r_dmag2, {THR_SHIFT{1'b0}}});
    assign w_rhs_c = CW'(r_rhs);
    assign w_acc   = ACCW'(r_wy) + ACCW'(r_wl) + ACCW'(BLEND_RND);
    assign w_blend = w_acc[BLEND_FRAC +: B];
    assign w_flag  = i_primed && (w_lhs_c > w_rhs_c);
    assign w_fsq   = r_filt * r_filt;

    always_ff @(posedge i_clk) begin
        case (i_state)
            S_MUL1: begin
                r_d     <= w_d;
                r_nq    <= w_nq;
                r_s2    <= w_s2[VW-1:0];
                r_oldsq <= QW'($unsigned(w_osq));
                r_wy    <= w_wy;
            end
            S_MUL2: begin
                r_dmag2 <= w_dmag2;
                r_dpos  <= !r_d[DW-1] && (r_d != '0);
                r_var   <= r_nq - r_s2;
                r_wl    <= w_wl;
            end
            S_MUL3: begin
                r_vt <= w_vt;
            end
            S_MUL4: begin
                r_rhs <= w_rhs;
            end
            S_DECIDE: begin
                r_flag <= w_flag;
                r_pos  <= r_dpos;
                r_filt <= w_flag ? w_blend : i_y;
            end
            S_SQUARE: begin
                r_fsq <= QW'($unsigned(w_fsq));
            end
            default: begin
            end
        endcase
    end

    assign o_verdict.flag = r_flag;
    assign o_verdict.pos  = r_pos;
    assign o_filt         = r_filt;
    assign o_oldsq        = r_oldsq;
    assign o_fsq          = r_fsq;

endmodule
